### design/fsq_token_quantizer_assert.svh
// Assertion macros for the FSQ token quantizer.
// Each macro checks an implication on the rising clock edge, outside reset.
`ifndef FSQ_TOKEN_QUANTIZER_ASSERT_SVH
`define FSQ_TOKEN_QUANTIZER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FSQ_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("fsq_token_quantizer assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define FSQ_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("fsq_token_quantizer assertion failed");

`endif

### design/fsq_pkg.sv
package fsq_pkg;

	// Field and register widths.
	localparam int IN_W      = 16;
	localparam int MAG_W     = 16;
	localparam int TOKEN_W   = 32;
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 2;
	localparam int DIMS_W    = 4;
	localparam int BASE_W    = 5;
	localparam int SCALE_W   = 16;
	localparam int OFFS_W    = 4;
	localparam int LVL_W     = 4;
	localparam int DIM_IDX_W = 3;

	// Quantizer limits.
	localparam int MAX_DIMS  = 8;
	localparam int MIN_BASE  = 2;
	localparam int MAX_BASE  = 16;

	// Reset values of the configuration registers.
	localparam int DIMS_RST  = 8;
	localparam int BASE_RST  = 3;
	localparam int SCALE_RST = 4092;
	localparam int OFFS_RST  = 1;

	// Shared multiplier operand and product widths.
	localparam int MUL_A_W   = 32;
	localparam int MUL_B_W   = 17;
	localparam int PROD_W    = MUL_A_W + MUL_B_W;

	// tanh datapath constants.
	localparam int LOG2E_Q14 = 23637;
	localparam int Z_RND     = 8192;
	localparam int Z_SHIFT   = 14;
	localparam int INTERP_RND = 128;
	localparam int EXP_W     = 17;
	localparam int EXP_ONE   = 65536;
	localparam int K_W       = 6;
	localparam int T_MAX     = 32767;
	localparam int T_W       = 15;

	// Divider geometry: quotient is known to stay below 2^DIV_Q_W.
	localparam int DIV_NUM_W = 32;
	localparam int DIV_DEN_W = 18;
	localparam int DIV_Q_W   = 16;
	localparam int DIV_CNT_W = $clog2(DIV_Q_W + 1);

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_DIMS_USED,
		CFG_LEVEL_BASE,
		CFG_TANH_SCALE,
		CFG_LEVEL_OFFSET
	} cfg_reg_t;

	// Divider status toward the sequencer.
	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	// 2^(-j/8) in Q16, j = 0..8.
	function automatic logic [EXP_W-1:0] exp2_entry(input logic [3:0] idx);
		logic [EXP_W-1:0] val;
		case (idx)
			4'd0: val = 17'd65536;
			4'd1: val = 17'd60097;
			4'd2: val = 17'd55109;
			4'd3: val = 17'd50535;
			4'd4: val = 17'd46341;
			4'd5: val = 17'd42495;
			4'd6: val = 17'd38968;
			4'd7: val = 17'd35734;
			4'd8: val = 17'd32768;
			default: val = 17'd32768;
		endcase
		return val;
	endfunction

endpackage

### design/fsq_mul_unit.sv
module fsq_mul_unit (
	input  logic                        clk,
	input  logic [fsq_pkg::MUL_A_W-1:0] op_a,
	input  logic [fsq_pkg::MUL_B_W-1:0] op_b,
	output logic [fsq_pkg::PROD_W-1:0]  prod
);
	import fsq_pkg::*;

	logic [PROD_W-1:0] prod_q;

	// One registered unsigned multiply; the product is read the following cycle.
	always_ff @(posedge clk) begin
		prod_q <= PROD_W'(op_a) * PROD_W'(op_b);
	end

	assign prod = prod_q;

endmodule

### design/fsq_div_unit.sv
module fsq_div_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [fsq_pkg::DIV_NUM_W-1:0] num,
	input  logic [fsq_pkg::DIV_DEN_W-1:0] den,
	output logic [fsq_pkg::DIV_Q_W-1:0]   quot,
	output fsq_pkg::div_stat_t            stat
);
	import fsq_pkg::*;

	logic [DIV_DEN_W-1:0] rem_q;
	logic [DIV_DEN_W-1:0] den_q;
	logic [DIV_Q_W-1:0]   num_lo_q;
	logic [DIV_Q_W-1:0]   quot_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [DIV_DEN_W:0]   trial;
	logic                 ge;

	// Restoring step: bring down one numerator bit and try the subtract.
	assign trial = {rem_q, num_lo_q[DIV_Q_W-1]};
	assign ge    = trial >= {1'b0, den_q};

	// The upper numerator half is below the divisor, so only the low half
	// produces quotient bits, one per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			done_q   <= 1'b0;
			cnt_q    <= '0;
			rem_q    <= '0;
			den_q    <= '0;
			num_lo_q <= '0;
			quot_q   <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q   <= 1'b1;
				cnt_q    <= DIV_CNT_W'(DIV_Q_W);
				rem_q    <= DIV_DEN_W'(num[DIV_NUM_W-1:DIV_NUM_W-DIV_Q_W]);
				num_lo_q <= num[DIV_Q_W-1:0];
				den_q    <= den;
				quot_q   <= '0;
			end else if (busy_q) begin
				rem_q    <= ge ? DIV_DEN_W'(trial - {1'b0, den_q}) : trial[DIV_DEN_W-1:0];
				quot_q   <= {quot_q[DIV_Q_W-2:0], ge};
				num_lo_q <= {num_lo_q[DIV_Q_W-2:0], 1'b0};
				cnt_q    <= cnt_q - 1'b1;
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign quot      = quot_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

### design/fsq_token_quantizer.sv
// An accepted item holds in_stall high while the sequencer works, so no new item is
// taken until the sequencer is back in idle, which the item that completes a token delays
// while the previous token waits at a stalled output. The token is registered at the emit step.
// Each item passes through the 16-step divider of the tanh and the shared multiplier.
// Reset (arst_n low, asynchronous) clears the partial token, loads the register
// defaults 8, 3, 4092 and 1, and empties the output register.
`include "fsq_token_quantizer_assert.svh"

module fsq_token_quantizer (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [fsq_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [fsq_pkg::CFG_W-1:0]     cfg_wdata,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [fsq_pkg::IN_W-1:0] proj_value,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [fsq_pkg::TOKEN_W-1:0]   token,
	output logic                          clipped
);
	import fsq_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE,
		S_MZ,
		S_ZK,
		S_MI,
		S_EX,
		S_DST,
		S_DIV,
		S_MP,
		S_RND,
		S_MA,
		S_ACC,
		S_RAD,
		S_EMIT
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic [DIMS_W-1:0]  dims_q;
	logic [BASE_W-1:0]  base_q;
	logic [SCALE_W-1:0] scale_q;
	logic [OFFS_W-1:0]  offs_q;

	// Token accumulation state.
	logic [TOKEN_W-1:0]   acc_q;
	logic [TOKEN_W-1:0]   radix_q;
	logic [DIM_IDX_W-1:0] dim_q;
	logic                 clip_q;

	// Per-item working registers.
	logic             neg_q;
	logic [MAG_W-1:0] mag_q;
	logic [K_W-1:0]   k_q;
	logic [2:0]       j_q;
	logic [7:0]       r_q;
	logic [EXP_W-1:0] e_q;
	logic [LVL_W-1:0] lvl_q;

	// Output register.
	logic               out_valid_q;
	logic [TOKEN_W-1:0] token_q;
	logic               clipped_q;

	// Shared units.
	logic [MUL_A_W-1:0]   mul_a;
	logic [MUL_B_W-1:0]   mul_b;
	logic [PROD_W-1:0]    prod;
	logic                 div_start;
	logic [DIV_NUM_W-1:0] div_num;
	logic [DIV_DEN_W-1:0] div_den;
	logic [DIV_Q_W-1:0]   div_quot;
	div_stat_t            div_stat;

	// Effective settings after range limiting.
	logic [BASE_W-1:0] base_eff;
	logic [DIMS_W-1:0] dims_eff;

	// Datapath intermediates.
	logic                 in_acc;
	logic                 out_acc;
	logic [MAG_W-1:0]     in_mag;
	logic [TOKEN_W-1:0]   z_sum;
	logic [16:0]          z_val;
	logic [21:0]          interp_sum;
	logic [EXP_W-1:0]     e_lin;
	logic [EXP_W-1:0]     e_shift;
	logic [EXP_W-1:0]     e_diff;
	logic [EXP_W:0]       e_plus;
	logic [T_W-1:0]       t_sat;
	logic [3:0]           q_int;
	logic                 round_up;
	logic [4:0]           q_rnd;
	logic signed [6:0]    lvl_signed;
	logic signed [6:0]    base_top;
	logic [DIMS_W-1:0]    count;

	assign in_acc  = in_valid && !in_stall;
	assign out_acc = out_valid_q && !out_stall;

	assign base_eff = (base_q < BASE_W'(MIN_BASE)) ? BASE_W'(MIN_BASE) :
		((base_q > BASE_W'(MAX_BASE)) ? BASE_W'(MAX_BASE) : base_q);
	assign dims_eff = (dims_q == '0) ? DIMS_W'(1) :
		((dims_q > DIMS_W'(MAX_DIMS)) ? DIMS_W'(MAX_DIMS) : dims_q);

	// Magnitude of the Q4.11 input; the most negative value maps to 32768.
	assign in_mag = proj_value[IN_W-1] ? MAG_W'(-proj_value) : MAG_W'(proj_value);

	// z = round(2|x| * log2(e)), split into integer k and fraction f.
	assign z_sum = prod[TOKEN_W-1:0] + TOKEN_W'(Z_RND);
	assign z_val = z_sum[Z_SHIFT+16:Z_SHIFT];

	// Linear interpolation of 2^(-f), then shift right by k.
	assign interp_sum = prod[21:0] + 22'(INTERP_RND);
	assign e_lin      = exp2_entry({1'b0, j_q}) - EXP_W'(interp_sum[21:8]);
	assign e_shift    = (k_q >= K_W'(EXP_W)) ? '0 : (e_lin >> k_q);

	// Divider operands for t = ((1-e) << 15 + (1+e)/2) / (1+e).
	assign e_diff  = EXP_W'(EXP_ONE - e_q);
	assign e_plus  = (EXP_W+1)'(EXP_ONE) + {1'b0, e_q};
	assign div_num = {e_diff, 15'b0} + DIV_NUM_W'(e_plus[EXP_W:1]);
	assign div_den = DIV_DEN_W'(e_plus);
	assign div_start = (state_q == S_DST);

	// Saturate the tanh magnitude to Q0.15.
	assign t_sat = (div_quot > DIV_Q_W'(T_MAX)) ? T_W'(T_MAX) : div_quot[T_W-1:0];

	// Round half to even on the Q.27 product, apply sign and offset.
	assign q_int    = prod[30:27];
	assign round_up = prod[26] && ((prod[25:0] != '0) || q_int[0]);
	assign q_rnd    = {1'b0, q_int} + 5'(round_up);
	assign lvl_signed = (neg_q ? -$signed({2'b0, q_rnd}) : $signed({2'b0, q_rnd})) +
		$signed({3'b0, offs_q});
	assign base_top = $signed({2'b0, base_eff - 1'b1});

	assign count = {1'b0, dim_q} + 1'b1;

	// Operand selection for the shared multiplier, by sequencer step.
	always_comb begin
		case (state_q)
			S_MZ: begin
				mul_a = MUL_A_W'({mag_q, 1'b0});
				mul_b = MUL_B_W'(LOG2E_Q14);
			end
			S_MI: begin
				mul_a = MUL_A_W'(exp2_entry({1'b0, j_q}) - exp2_entry({1'b0, j_q} + 4'd1));
				mul_b = MUL_B_W'(r_q);
			end
			S_MP: begin
				mul_a = MUL_A_W'(t_sat);
				mul_b = MUL_B_W'(scale_q);
			end
			S_MA: begin
				mul_a = radix_q;
				mul_b = MUL_B_W'(lvl_q);
			end
			S_ACC: begin
				mul_a = radix_q;
				mul_b = MUL_B_W'(base_eff);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	fsq_mul_unit u_mul (
		.clk  (clk),
		.op_a (mul_a),
		.op_b (mul_b),
		.prod (prod)
	);

	fsq_div_unit u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.quot   (div_quot),
		.stat   (div_stat)
	);

	// Sequencer with configuration, accumulation and output registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			dims_q      <= DIMS_W'(DIMS_RST);
			base_q      <= BASE_W'(BASE_RST);
			scale_q     <= SCALE_W'(SCALE_RST);
			offs_q      <= OFFS_W'(OFFS_RST);
			acc_q       <= '0;
			radix_q     <= TOKEN_W'(1);
			dim_q       <= '0;
			clip_q      <= 1'b0;
			neg_q       <= 1'b0;
			mag_q       <= '0;
			k_q         <= '0;
			j_q         <= '0;
			r_q         <= '0;
			e_q         <= '0;
			lvl_q       <= '0;
			out_valid_q <= 1'b0;
			token_q     <= '0;
			clipped_q   <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_reg_t'(cfg_index))
					CFG_DIMS_USED:    dims_q  <= cfg_wdata[DIMS_W-1:0];
					CFG_LEVEL_BASE:   base_q  <= cfg_wdata[BASE_W-1:0];
					CFG_TANH_SCALE:   scale_q <= cfg_wdata[SCALE_W-1:0];
					CFG_LEVEL_OFFSET: offs_q  <= cfg_wdata[OFFS_W-1:0];
					default: ;
				endcase
			end

			// The emit step refills the output register itself.
			if (out_acc && state_q != S_EMIT) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						neg_q   <= proj_value[IN_W-1];
						mag_q   <= in_mag;
						state_q <= S_MZ;
					end
				end
				S_MZ: begin
					state_q <= S_ZK;
				end
				S_ZK: begin
					k_q     <= z_val[16:11];
					j_q     <= z_val[10:8];
					r_q     <= z_val[7:0];
					state_q <= S_MI;
				end
				S_MI: begin
					state_q <= S_EX;
				end
				S_EX: begin
					e_q     <= e_shift;
					state_q <= S_DST;
				end
				S_DST: begin
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (div_stat.done) begin
						state_q <= S_MP;
					end
				end
				S_MP: begin
					state_q <= S_RND;
				end
				S_RND: begin
					if (lvl_signed < 0) begin
						lvl_q  <= '0;
						clip_q <= 1'b1;
					end else if (lvl_signed > base_top) begin
						lvl_q  <= LVL_W'(base_eff - 1'b1);
						clip_q <= 1'b1;
					end else begin
						lvl_q <= lvl_signed[LVL_W-1:0];
					end
					state_q <= S_MA;
				end
				S_MA: begin
					state_q <= S_ACC;
				end
				S_ACC: begin
					acc_q   <= acc_q + prod[TOKEN_W-1:0];
					state_q <= S_RAD;
				end
				S_RAD: begin
					radix_q <= prod[TOKEN_W-1:0];
					if (count >= dims_eff) begin
						state_q <= S_EMIT;
					end else begin
						dim_q   <= count[DIM_IDX_W-1:0];
						state_q <= S_IDLE;
					end
				end
				S_EMIT: begin
					// Wait until the output register is free, then hand the token over.
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						token_q     <= acc_q;
						clipped_q   <= clip_q;
						acc_q       <= '0;
						radix_q     <= TOKEN_W'(1);
						dim_q       <= '0;
						clip_q      <= 1'b0;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign token     = token_q;
	assign clipped   = clipped_q;

	// The divider only runs while the sequencer waits on it.
	`FSQ_ASSERT_SAME(a_div_busy_in_wait, div_stat.busy, state_q == S_DIV)
	// A new token appears only from the emit step.
	`FSQ_ASSERT_SAME(a_out_from_emit, $rose(out_valid_q), $past(state_q == S_EMIT))
	// The clipped level never exceeds the top level of the radix.
	`FSQ_ASSERT_SAME(a_lvl_in_range, state_q == S_MA, lvl_q <= LVL_W'(base_eff - 1'b1))
	// An accepted item starts the multiply for the tanh argument.
	`FSQ_ASSERT_NEXT(a_accept_starts, in_valid && !in_stall, state_q == S_MZ)

endmodule
